// ===== design/ccd_pkg.sv =====
`timescale 1ns / 1ps
package ccd_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int CLEAN_TRIGGER = 100;
	localparam int TIME_W = 48;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = 7;
	localparam int DUR_W = 40;
	localparam int FREQ_W = 32;
	localparam int AGE_W = 40;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 64;

	localparam logic [AGE_W-1:0] AGE_RESET = 40'd5000000000;
	localparam logic [ADDR_W-1:0] ADDR_AGE = 4'h0;

	typedef enum logic [1:0] {
		REQ_ADD = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NOP = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_FULL = 2'd1,
		STAT_BADSLOT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		TK_ADD = 2'd0,
		TK_FETCH = 2'd1,
		TK_QUERY = 2'd2,
		TK_AGE = 2'd3
	} tok_kind_t;

	// Token that walks the cell chain, one cell per clock.
	typedef struct packed {
		logic vld;
		tok_kind_t kind;
		logic found;
		logic hit;
		logic [IDX_W-1:0] slot;
		logic [CNT_W-1:0] count;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] stop_time;
		logic [FREQ_W-1:0] chan;
	} tok_t;

endpackage

// ===== design/ccd_cell.sv =====
`timescale 1ns / 1ps
module ccd_cell import ccd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic clear,
	input logic [AGE_W-1:0] age_thr,
	input logic [IDX_W-1:0] cell_idx,
	input tok_t tok_in,
	output tok_t tok_out
);

	logic valid_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] stop_q;
	logic [FREQ_W-1:0] chan_q;
	tok_t tok_q;
	tok_t tok_d;
	logic claim;
	logic expire;
	logic overlap;
	logic match;
	logic [TIME_W-1:0] age_gap;

	always_comb begin
		age_gap = tok_in.start_time - stop_q;
		claim = tok_in.vld && (tok_in.kind == TK_ADD) && !tok_in.found && !valid_q;
		expire = tok_in.vld && (tok_in.kind == TK_AGE) && valid_q &&
			(tok_in.start_time > stop_q) && (age_gap > TIME_W'(age_thr));
		// Positive overlap exactly when both ends lie beyond both starts.
		overlap = (tok_in.stop_time > start_q) && (stop_q > tok_in.start_time) &&
			(tok_in.stop_time > tok_in.start_time) && (stop_q > start_q);
		match = tok_in.found && valid_q && (chan_q == tok_in.chan) &&
			(cell_idx != tok_in.slot);
		tok_d = tok_in;
		case (tok_in.kind)
			TK_ADD: begin
				if (claim) begin
					tok_d.found = 1'b1;
					tok_d.slot = cell_idx;
				end
				if (valid_q || claim) begin
					tok_d.count = tok_in.count + CNT_W'(1);
				end
			end
			TK_FETCH: begin
				if (cell_idx == tok_in.slot) begin
					tok_d.found = valid_q;
					tok_d.start_time = start_q;
					tok_d.stop_time = stop_q;
					tok_d.chan = chan_q;
				end
			end
			TK_QUERY: begin
				if (match && overlap) begin
					tok_d.hit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (clear) begin
				valid_q <= 1'b0;
			end else if (claim) begin
				valid_q <= 1'b1;
			end else if (expire) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			start_q <= tok_in.start_time;
			stop_q <= tok_in.stop_time;
			chan_q <= tok_in.chan;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== design/ccd_seq.sv =====
`timescale 1ns / 1ps
module ccd_seq import ccd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [1:0] req_type,
	input logic [TIME_W-1:0] now,
	input logic [DUR_W-1:0] duration,
	input logic [FREQ_W-1:0] frequency,
	input logic [SLOT_W-1:0] query_slot,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic [SLOT_W-1:0] slot,
	output logic destroyed,
	output logic [1:0] status,
	output logic clear,
	output tok_t seed,
	input tok_t tail_tok
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ADD = 6'b000010,
		S_FETCH = 6'b000100,
		S_QUERY = 6'b001000,
		S_AGE = 6'b010000,
		S_WRITE = 6'b100000
	} state_t;

	localparam int EXT_W = IDX_W + SLOT_W;

	state_t state_q, state_d;
	tok_t seed_q, seed_d;
	logic clear_q, clear_d;
	logic [SLOT_W-1:0] res_slot_q, res_slot_d;
	logic res_dst_q, res_dst_d;
	status_t res_stat_q, res_stat_d;
	logic rsp_valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic destroyed_q;
	status_t status_q;
	logic [TIME_W:0] end_sum;
	logic [EXT_W-1:0] qs_ext;
	logic [EXT_W-1:0] tail_slot_ext;
	logic qs_bad;
	logic out_free;
	logic load;

	assign end_sum = {1'b0, now} + (TIME_W + 1)'(duration);
	assign qs_ext = EXT_W'(query_slot);
	assign tail_slot_ext = EXT_W'(tail_tok.slot);
	assign qs_bad = qs_ext >= EXT_W'(TABLE_DEPTH);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign load = (state_q == S_WRITE) && out_free;

	always_comb begin
		state_d = state_q;
		seed_d = seed_q;
		seed_d.vld = 1'b0;
		clear_d = 1'b0;
		res_slot_d = res_slot_q;
		res_dst_d = res_dst_q;
		res_stat_d = res_stat_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					res_slot_d = '0;
					res_dst_d = 1'b0;
					res_stat_d = STAT_OK;
					state_d = S_WRITE;
					case (req_type)
						REQ_ADD: begin
							seed_d = '0;
							seed_d.vld = 1'b1;
							seed_d.kind = TK_ADD;
							seed_d.start_time = now;
							// The end time saturates at the largest time.
							seed_d.stop_time = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
							seed_d.chan = frequency;
							state_d = S_ADD;
						end
						REQ_QUERY: begin
							if (qs_bad) begin
								res_stat_d = STAT_BADSLOT;
							end else begin
								seed_d = '0;
								seed_d.vld = 1'b1;
								seed_d.kind = TK_FETCH;
								seed_d.slot = qs_ext[IDX_W-1:0];
								state_d = S_FETCH;
							end
						end
						REQ_CLEAR: begin
							clear_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_ADD: begin
				if (tail_tok.vld) begin
					if (!tail_tok.found) begin
						res_stat_d = STAT_FULL;
						state_d = S_WRITE;
					end else begin
						res_slot_d = tail_slot_ext[SLOT_W-1:0];
						if (tail_tok.count > CNT_W'(CLEAN_TRIGGER)) begin
							// The aging pass reuses the add token; it still carries now.
							seed_d = tail_tok;
							seed_d.kind = TK_AGE;
							state_d = S_AGE;
						end else begin
							state_d = S_WRITE;
						end
					end
				end
			end
			S_FETCH: begin
				if (tail_tok.vld) begin
					if (!tail_tok.found) begin
						res_stat_d = STAT_BADSLOT;
						state_d = S_WRITE;
					end else begin
						seed_d = tail_tok;
						seed_d.kind = TK_QUERY;
						seed_d.hit = 1'b0;
						state_d = S_QUERY;
					end
				end
			end
			S_QUERY: begin
				if (tail_tok.vld) begin
					res_dst_d = tail_tok.hit;
					state_d = S_WRITE;
				end
			end
			S_AGE: begin
				if (tail_tok.vld) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seed_q <= '0;
			clear_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			seed_q <= seed_d;
			clear_q <= clear_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_slot_q <= res_slot_d;
		res_dst_q <= res_dst_d;
		res_stat_q <= res_stat_d;
		if (load) begin
			slot_q <= res_slot_q;
			destroyed_q <= res_dst_q;
			status_q <= res_stat_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot = slot_q;
	assign destroyed = destroyed_q;
	assign status = status_q;
	assign clear = clear_q;
	assign seed = seed_q;

`ifndef SYNTH
	a_seed_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		seed_q.vld |=> !seed_q.vld)
		else $error("walk token injected on two cycles in a row");

	a_tail_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tail_tok.vld |-> (state_q == S_ADD || state_q == S_FETCH ||
			state_q == S_QUERY || state_q == S_AGE))
		else $error("token left the chain outside a walk");

	a_clear_write: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> (state_q == S_WRITE))
		else $error("table cleared outside a clear request");

	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q == STAT_FULL)) |-> (slot_q == '0))
		else $error("rejected add reports a slot");

	a_dst_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && destroyed_q) |-> (status_q == STAT_OK))
		else $error("collision reported with an error status");
`endif

endmodule

// ===== design/channel_collision_detector.sv =====
`timescale 1ns / 1ps
// Table of TABLE_DEPTH reception events, one event per cell in a chain of cells. Each
// add or query request is injected as a token at the head of the chain and moves one cell
// per clock; the cells compare and update their own entry as the token passes. When more
// than CLEAN_TRIGGER entries are live after an add, the aging pass follows. A query makes
// one pass that fetches the queried entry and a second that compares it against every
// other entry. A query of an empty slot ends after the first pass. Clear and the unused
// request code make no pass, and any stall on the result side delays the result. One
// request is worked on at a time. The next request is taken in the cycle after the
// previous result moves into the output register. The age threshold register is written
// at byte address 0 and should only be changed while no request is in flight.
module channel_collision_detector import ccd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	input logic req_valid,
	output logic req_stall,
	input logic [1:0] req_type,
	input logic [TIME_W-1:0] now,
	input logic [DUR_W-1:0] duration,
	input logic [FREQ_W-1:0] frequency,
	input logic [SLOT_W-1:0] query_slot,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic [SLOT_W-1:0] slot,
	output logic destroyed,
	output logic [1:0] status
);

	logic [AGE_W-1:0] age_q;
	logic clear;
	tok_t chain [TABLE_DEPTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= AGE_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_AGE)) begin
			age_q <= pwdata[AGE_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_AGE) ? DATA_W'(age_q) : '0;

	ccd_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.now(now),
		.duration(duration),
		.frequency(frequency),
		.query_slot(query_slot),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.slot(slot),
		.destroyed(destroyed),
		.status(status),
		.clear(clear),
		.seed(chain[0]),
		.tail_tok(chain[TABLE_DEPTH])
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ccd_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.clear(clear),
			.age_thr(age_q),
			.cell_idx(IDX_W'(i)),
			.tok_in(chain[i]),
			.tok_out(chain[i+1])
		);
	end

endmodule
